@@ src/lzw_pkg.sv @@
package lzw_pkg;

  // stream header
  localparam logic [7:0] HdrMagic0 = 8'h1f;
  localparam logic [7:0] HdrMagic1 = 8'h9d;
  localparam logic [7:0] HdrBlockFlag = 8'h80;

  localparam int unsigned ClearCode = 256;
  localparam int unsigned FirstCode = 257;
  localparam int unsigned StartWidth = 9;
  localparam int unsigned HeaderBits = 24;
  localparam logic [15:0] CheckGapReset = 16'd2000;

  // ratio limits
  localparam logic [31:0] RatioBigIn = 32'h007f_ffff;
  localparam logic [31:0] RatioMax = 32'h7fff_ffff;

  // request from the encoder to the output buffer
  typedef struct packed {
    logic       push;
    logic       flush;
    logic [7:0] data;
  } ob_req_t;

endpackage

@@ src/lzw_dict.sv @@
module lzw_dict #(
  parameter int unsigned Depth = 5003,
  parameter int unsigned AddrW = 13,
  parameter int unsigned DataW = 33
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lzw_div.sv @@
module lzw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= num_i;
        den_q  <= den_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], quo_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ src/lzw_obuf.sv @@
module lzw_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lzw_pkg::ob_req_t req_i,
  output logic             rdy_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  // one byte is held back so the last byte before a flush can be marked
  logic       hvld_q, ovld_q, olast_q;
  logic [7:0] hold_q, odata_q;
  logic       out_free;

  assign out_free = !ovld_q || m_axis_tready_i;
  assign rdy_o    = !hvld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvld_q  <= 1'b0;
      ovld_q  <= 1'b0;
      olast_q <= 1'b0;
      hold_q  <= '0;
      odata_q <= '0;
    end else begin
      if (m_axis_tready_i) begin
        ovld_q <= 1'b0;
      end
      if (req_i.push) begin
        if (hvld_q) begin
          ovld_q  <= 1'b1;
          odata_q <= hold_q;
          olast_q <= 1'b0;
        end
        hold_q <= req_i.data;
        hvld_q <= 1'b1;
      end else if (req_i.flush && hvld_q) begin
        ovld_q  <= 1'b1;
        odata_q <= hold_q;
        olast_q <= 1'b1;
        hvld_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

@@ src/lzw_compress_stream.sv @@
// channel   dir  tdata               tuser  tlast
// s_axis    in   [7:0] data_byte     -      final_byte
// m_axis    out  [7:0] out_byte      -      out_last
// cfg       in   [15:0] ratio_gap    -      -  (write on cfg_we_i)
//
// a byte that extends the prefix runs the hash fold (a single quotient bit at 12-bit codes)
// and one read per dictionary probe; a miss also drains its code to the output, a width
// step adds the pad bytes, and a ratio check uses the serial divider.
// after reset, a table clear or a stream end, a clearing pass over all HASH_ENTRIES
// slots runs before the next byte is taken.
// a stalled output holds the encoder; one byte waits ahead of the output register.
module lzw_compress_stream #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned HASH_ENTRIES  = 5003
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o
);

  localparam int unsigned CW   = MAX_CODE_BITS;
  localparam int unsigned IW   = $clog2(HASH_ENTRIES);
  localparam int unsigned KW   = CW + 8;
  localparam int unsigned DW   = 1 + KW + CW;
  localparam int unsigned NW   = CW + 1;
  localparam int unsigned WW   = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned AW   = CW + 8;
  localparam int unsigned PW   = $clog2(8 * MAX_CODE_BITS + 8);
  localparam int unsigned GW   = $clog2(8 * MAX_CODE_BITS + 17);
  localparam int unsigned HW   = (CW > IW) ? CW : IW;
  localparam int unsigned QMAX = ((1 << CW) - 1) / HASH_ENTRIES;
  localparam int unsigned QB   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int unsigned QCW  = $clog2(QB + 1);
  localparam int unsigned PCW  = $clog2(HASH_ENTRIES + 1);
  localparam logic [HW-1:0] Dv0 = HW'(HASH_ENTRIES << (QB - 1));

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_HDR, ST_HASH, ST_RD, ST_CHK, ST_MISS, ST_DRAIN,
    ST_AEW, ST_PADSET, ST_PADDONE, ST_AER, ST_DIV, ST_RCMP, ST_CLRCODE,
    ST_FIN, ST_FLB, ST_END
  } state_e;

  function automatic logic [NW-1:0] lim(input logic [WW-1:0] w);
    lim = (NW'(1) << w) + NW'(w < WW'(CW));
  endfunction

  state_e         state_q, ret_q;
  logic [15:0]    gap_q;
  logic [7:0]     c_q;
  logic           fin_q, open_q, growing_q, empty_q, clr_pend_q, pad_clr_q;
  logic [CW-1:0]  prefix_q;
  logic [WW-1:0]  width_q;
  logic [NW-1:0]  nfc_q, limit_q;
  logic [31:0]    bytes_q, bits_q, last_q, next_q, quot_q;
  logic [AW-1:0]  acc_q;
  logic [PW-1:0]  pend_q;
  logic [GW-1:0]  grp_q;
  logic [HW-1:0]  hv_q, dv_q;
  logic [QCW-1:0] hcnt_q;
  logic [IW-1:0]  slot_q, step_q, clr_q;
  logic [PCW-1:0] probes_q;
  logic [1:0]     hdr_q;

  // dictionary entry: valid, key, code
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata, mem_rdata;
  logic           rd_vld;
  logic [KW-1:0]  rd_key, key;
  logic [CW-1:0]  rd_code;

  lzw_pkg::ob_req_t ob_req;
  logic             ob_rdy;

  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quot;

  // shared bit packer
  logic [CW-1:0] put_v, put_mask;
  logic [AW-1:0] put_acc;
  logic [GW-1:0] span, put_grp, grp_sum;
  logic [IW-1:0] st_raw, slot_next;
  logic [IW:0]   slot_wrap;
  logic [HW-1:0] hv_in;
  logic [31:0]   nbytes;
  logic [7:0]    hdr_byte;

  assign key    = {prefix_q, c_q};
  assign rd_vld = mem_rdata[DW-1];
  assign rd_key = mem_rdata[DW-2 -: KW];
  assign rd_code = mem_rdata[CW-1:0];

  assign put_v    = (state_q == ST_CLRCODE) ? CW'(lzw_pkg::ClearCode) : prefix_q;
  assign put_mask = (CW'(1) << width_q) - CW'(1);
  assign put_acc  = acc_q | (AW'(put_v & put_mask) << pend_q);
  assign span     = GW'({width_q, 3'b000});
  assign grp_sum  = grp_q + GW'(width_q);
  assign put_grp  = (grp_sum >= span) ? grp_sum - span : grp_sum;

  assign hv_in    = HW'({s_axis_tdata_i, (CW - 8)'(0)} ^ prefix_q);
  assign st_raw   = IW'(HASH_ENTRIES - 1) - IW'(hv_q);
  assign slot_wrap = {1'b0, slot_q} + (IW + 1)'(HASH_ENTRIES) - {1'b0, step_q};
  assign slot_next = (slot_q >= step_q) ? slot_q - step_q : slot_wrap[IW-1:0];
  assign nbytes   = bits_q >> 3;

  always_comb begin
    case (hdr_q)
      2'd0:    hdr_byte = lzw_pkg::HdrMagic0;
      2'd1:    hdr_byte = lzw_pkg::HdrMagic1;
      default: hdr_byte = 8'(MAX_CODE_BITS) | lzw_pkg::HdrBlockFlag;
    endcase
  end

  always_comb begin
    ob_req = '0;
    case (state_q)
      ST_HDR: begin
        ob_req.push = ob_rdy;
        ob_req.data = hdr_byte;
      end
      ST_DRAIN: begin
        ob_req.push = ob_rdy && (pend_q >= PW'(8));
        ob_req.data = acc_q[7:0];
      end
      ST_FLB: begin
        ob_req.push = ob_rdy && (pend_q != '0);
        ob_req.data = acc_q[7:0];
      end
      ST_END: begin
        ob_req.flush = ob_rdy;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = {1'b1, key, nfc_q[CW-1:0]};
    if (state_q == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_MISS) begin
      mem_we = growing_q && empty_q;
    end
  end

  always_comb begin
    if (bytes_q > lzw_pkg::RatioBigIn) begin
      div_num = bytes_q;
      div_den = nbytes >> 8;
    end else begin
      div_num = bytes_q << 8;
      div_den = nbytes;
    end
    div_start = (state_q == ST_AER) && !growing_q && (bytes_q >= next_q)
                && (div_den != '0);
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      ret_q      <= ST_IDLE;
      gap_q      <= lzw_pkg::CheckGapReset;
      c_q        <= '0;
      fin_q      <= 1'b0;
      open_q     <= 1'b0;
      growing_q  <= 1'b1;
      empty_q    <= 1'b0;
      clr_pend_q <= 1'b0;
      pad_clr_q  <= 1'b0;
      prefix_q   <= '0;
      width_q    <= WW'(lzw_pkg::StartWidth);
      nfc_q      <= NW'(lzw_pkg::FirstCode);
      limit_q    <= lim(WW'(lzw_pkg::StartWidth));
      bytes_q    <= '0;
      bits_q     <= 32'(lzw_pkg::HeaderBits);
      last_q     <= '0;
      next_q     <= 32'(lzw_pkg::CheckGapReset);
      quot_q     <= '0;
      acc_q      <= '0;
      pend_q     <= '0;
      grp_q      <= '0;
      hv_q       <= '0;
      dv_q       <= '0;
      hcnt_q     <= '0;
      slot_q     <= '0;
      step_q     <= '0;
      clr_q      <= '0;
      probes_q   <= '0;
      hdr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == IW'(HASH_ENTRIES - 1)) begin
            clr_q      <= '0;
            clr_pend_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            c_q   <= s_axis_tdata_i;
            fin_q <= s_axis_tlast_i;
            if (!open_q) begin
              hdr_q   <= '0;
              state_q <= ST_HDR;
            end else begin
              bytes_q <= bytes_q + 32'd1;
              hv_q    <= hv_in;
              dv_q    <= Dv0;
              hcnt_q  <= QCW'(QB);
              state_q <= ST_HASH;
            end
          end
        end
        ST_HDR: begin
          if (ob_rdy) begin
            hdr_q <= hdr_q + 2'd1;
            if (hdr_q == 2'd2) begin
              prefix_q <= CW'(c_q);
              bytes_q  <= 32'd1;
              next_q   <= 32'(gap_q);
              open_q   <= 1'b1;
              state_q  <= ST_FIN;
            end
          end
        end
        ST_HASH: begin
          // fold the hash into the table, one quotient bit a cycle
          if (hcnt_q != '0) begin
            if (hv_q >= dv_q) begin
              hv_q <= hv_q - dv_q;
            end
            dv_q   <= dv_q >> 1;
            hcnt_q <= hcnt_q - QCW'(1);
          end else begin
            slot_q   <= IW'(hv_q);
            step_q   <= (st_raw == '0) ? IW'(1) : st_raw;
            probes_q <= '0;
            state_q  <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (!rd_vld) begin
            empty_q <= 1'b1;
            state_q <= ST_MISS;
          end else if (rd_key == key) begin
            prefix_q <= rd_code;
            state_q  <= ST_FIN;
          end else if (probes_q == PCW'(HASH_ENTRIES - 1)) begin
            empty_q <= 1'b0;
            state_q <= ST_MISS;
          end else begin
            probes_q <= probes_q + PCW'(1);
            slot_q   <= slot_next;
            state_q  <= ST_RD;
          end
        end
        ST_MISS: begin
          acc_q    <= put_acc;
          pend_q   <= pend_q + PW'(width_q);
          bits_q   <= bits_q + 32'(width_q);
          grp_q    <= put_grp;
          prefix_q <= CW'(c_q);
          if (growing_q) begin
            nfc_q <= nfc_q + NW'(1);
          end
          ret_q   <= ST_AEW;
          state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (pend_q < PW'(8)) begin
            state_q <= ret_q;
          end else if (ob_rdy) begin
            acc_q  <= acc_q >> 8;
            pend_q <= pend_q - PW'(8);
          end
        end
        ST_AEW: begin
          state_q <= ST_AER;
          if (growing_q && (nfc_q >= limit_q)) begin
            if (width_q < WW'(CW)) begin
              pad_clr_q <= 1'b0;
              state_q   <= ST_PADSET;
            end else begin
              growing_q <= 1'b0;
            end
          end
        end
        ST_PADSET: begin
          if (grp_q != '0) begin
            pend_q <= pend_q + PW'(span - grp_q);
            bits_q <= bits_q + 32'(span - grp_q);
          end
          grp_q   <= '0;
          ret_q   <= ST_PADDONE;
          state_q <= ST_DRAIN;
        end
        ST_PADDONE: begin
          if (pad_clr_q) begin
            width_q   <= WW'(lzw_pkg::StartWidth);
            limit_q   <= lim(WW'(lzw_pkg::StartWidth));
            nfc_q     <= NW'(lzw_pkg::FirstCode);
            growing_q <= 1'b1;
            state_q   <= ST_FIN;
          end else begin
            width_q <= width_q + WW'(1);
            limit_q <= lim(width_q + WW'(1));
            state_q <= ST_AER;
          end
        end
        ST_AER: begin
          if (!growing_q && (bytes_q >= next_q)) begin
            next_q <= bytes_q + 32'(gap_q);
            if (div_den == '0) begin
              quot_q  <= lzw_pkg::RatioMax;
              state_q <= ST_RCMP;
            end else begin
              state_q <= ST_DIV;
            end
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            quot_q  <= div_quot;
            state_q <= ST_RCMP;
          end
        end
        ST_RCMP: begin
          if (quot_q >= last_q) begin
            last_q  <= quot_q;
            state_q <= ST_FIN;
          end else begin
            last_q     <= '0;
            clr_pend_q <= 1'b1;
            state_q    <= ST_CLRCODE;
          end
        end
        ST_CLRCODE: begin
          acc_q     <= put_acc;
          pend_q    <= pend_q + PW'(width_q);
          bits_q    <= bits_q + 32'(width_q);
          grp_q     <= put_grp;
          pad_clr_q <= 1'b1;
          ret_q     <= ST_PADSET;
          state_q   <= ST_DRAIN;
        end
        ST_FIN: begin
          if (fin_q) begin
            acc_q   <= put_acc;
            pend_q  <= pend_q + PW'(width_q);
            bits_q  <= bits_q + 32'(width_q);
            grp_q   <= put_grp;
            ret_q   <= ST_FLB;
            state_q <= ST_DRAIN;
          end else begin
            state_q <= ST_END;
          end
        end
        ST_FLB: begin
          if (pend_q == '0) begin
            state_q <= ST_END;
          end else if (ob_rdy) begin
            pend_q  <= '0;
            acc_q   <= '0;
            state_q <= ST_END;
          end
        end
        ST_END: begin
          if (ob_rdy) begin
            if (fin_q) begin
              open_q     <= 1'b0;
              prefix_q   <= '0;
              width_q    <= WW'(lzw_pkg::StartWidth);
              limit_q    <= lim(WW'(lzw_pkg::StartWidth));
              nfc_q      <= NW'(lzw_pkg::FirstCode);
              growing_q  <= 1'b1;
              bytes_q    <= '0;
              bits_q     <= 32'(lzw_pkg::HeaderBits);
              grp_q      <= '0;
              last_q     <= '0;
              next_q     <= 32'(gap_q);
              acc_q      <= '0;
              pend_q     <= '0;
              state_q    <= ST_CLR;
            end else if (clr_pend_q) begin
              state_q <= ST_CLR;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  lzw_dict #(
    .Depth (HASH_ENTRIES),
    .AddrW (IW),
    .DataW (DW)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (slot_q),
    .rdata_o (mem_rdata)
  );

  lzw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  lzw_obuf u_obuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (ob_req),
    .rdy_o           (ob_rdy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // packer leaves less than a byte between items
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pend_q < PW'(8))
    else $error("bit packer holds a whole byte while idle");

  // code width stays in its range
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q >= WW'(lzw_pkg::StartWidth) && width_q <= WW'(CW))
    else $error("code width out of range");

  // a finished stream leaves through a clearing pass
  a_fin_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_END && ob_rdy && fin_q |=> state_q == ST_CLR && !open_q)
    else $error("stream end did not restart the table");

  // dictionary writes only on a miss with a free slot or in the clearing pass
  a_mem_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_CLR || (state_q == ST_MISS && empty_q && growing_q))
    else $error("unexpected dictionary write");

endmodule
